// ----- hdl/swmnp_pkg.sv -----
//------------------------------------------------------------------------------
// swmnp_pkg
// Shared types and constants for the skin weight merge, normalize and pack unit.
//------------------------------------------------------------------------------
`default_nettype none
package swmnp_pkg;

  // Input word: one bone and weight pair.
  typedef struct packed {
    logic [7:0]         bone_index;
    logic signed [23:0] bone_weight;
    logic               pair_valid;
    logic               last_pair;
  } in_word_t;

  // Output word: a header or one packed pair.
  typedef struct packed {
    logic       is_header;
    logic [3:0] pair_count;
    logic [7:0] out_bone;
    logic [7:0] weight_code;
    logic       clamped_flag;
    logic       sum_off_flag;
    logic       overflow_flag;
    logic       out_last;
  } out_word_t;

  // Command from the front part to the back part.
  typedef struct packed {
    logic       store;
    logic       last;
    logic [7:0] bone;
    logic [23:0] weight;
  } cmd_t;

  localparam logic [15:0] TOL_RESET = 16'd3277;

endpackage
`default_nettype wire

// ----- hdl/swmnp_front.sv -----
//------------------------------------------------------------------------------
// swmnp_front
// Accepts input words and turns those that do something into commands.
//------------------------------------------------------------------------------
`default_nettype none
module swmnp_front (
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire swmnp_pkg::in_word_t in_data,
  output logic                    cmd_valid,
  input  wire logic               cmd_full,
  output swmnp_pkg::cmd_t         cmd_data
);
  // Empty words are absorbed; others are forwarded into the queue.
  assign in_stall = cmd_full;
  assign cmd_valid = in_valid && !cmd_full && (in_data.pair_valid || in_data.last_pair);
  assign cmd_data.store  = in_data.pair_valid;
  assign cmd_data.last   = in_data.last_pair;
  assign cmd_data.bone   = in_data.bone_index;
  assign cmd_data.weight = in_data.bone_weight;
endmodule
`default_nettype wire

// ----- hdl/swmnp_queue.sv -----
//------------------------------------------------------------------------------
// swmnp_queue
// Small command queue between the front and back parts.
//------------------------------------------------------------------------------
`default_nettype none
module swmnp_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire swmnp_pkg::cmd_t wr_data,
  output logic                 full,
  input  wire logic            rd_en,
  output logic                 not_empty,
  output swmnp_pkg::cmd_t      rd_data
);
  swmnp_pkg::cmd_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full = cnt_r == 3'd4;
  assign not_empty = cnt_r != 3'd0;
  assign rd_data = mem_r[rp_r];

  // Payload slots.
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_en} - {2'd0, rd_en};
    end
  end
endmodule
`default_nettype wire

// ----- hdl/swmnp_back.sv -----
//------------------------------------------------------------------------------
// swmnp_back
// Stores pairs, merges duplicates, sums, divides and emits the vertex.
//------------------------------------------------------------------------------
`default_nettype none
module swmnp_back #(
  parameter int MAX_PAIRS = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [15:0]      tol,
  input  wire logic             cmd_avail,
  input  wire swmnp_pkg::cmd_t  cmd_data,
  output logic                  cmd_take,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output swmnp_pkg::out_word_t  out_data
);
  localparam int CAP = MAX_PAIRS - 1;
  localparam int IW = $clog2(MAX_PAIRS);
  localparam int SW = 24 + IW + 1;
  localparam int DW = SW + 10;

  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001, S_SCAN = 7'b0000010, S_FIN = 7'b0000100,
    S_HDR  = 7'b0001000, S_DIV  = 7'b0010000, S_EMIT = 7'b0100000,
    S_DONE = 7'b1000000
  } st_t;

  st_t st_r;
  logic [7:0]          b_r [CAP];
  logic signed [SW-1:0] w_r [CAP];
  logic                c_r [CAP];
  logic [IW-1:0] n_r, i_r, j_r;
  logic          drop_r;
  logic signed [SW-1:0] sum_r;
  logic [DW-1:0] rem_r, quo_r;
  logic [5:0]    dcnt_r;
  logic          ovalid_r;
  swmnp_pkg::out_word_t odata_r;

  logic out_free;
  logic out_load;
  assign out_free = !ovalid_r || !out_stall;
  assign out_load = out_free && (st_r == S_HDR || st_r == S_EMIT);
  assign out_valid = ovalid_r;
  assign out_data = odata_r;
  assign cmd_take = (st_r == S_LOAD) && cmd_avail;

  // Sum check and divisor terms.
  logic [SW+WEIGHT_FRAC_BITS+1:0] one, sum_dev, lhs, rhs;
  logic [DW-1:0] div_d, num;
  assign one  = (SW+WEIGHT_FRAC_BITS+2)'(1) << WEIGHT_FRAC_BITS;
  assign sum_dev = ($signed({2'b0, sum_r}) >= $signed(one)) ?
                (SW+WEIGHT_FRAC_BITS+2)'(sum_r) - one : one - (SW+WEIGHT_FRAC_BITS+2)'(sum_r);
  assign lhs  = sum_dev << 16;
  assign rhs  = (SW+WEIGHT_FRAC_BITS+2)'(tol) << WEIGHT_FRAC_BITS;
  assign div_d = DW'(sum_r) << 1;
  assign num = DW'(w_r[i_r]) * DW'(510) + DW'(sum_r);

  logic [DW:0] trial;
  assign trial = {rem_r, quo_r[DW-1]} - {1'b0, div_d};

  // Output valid: set when a new word is loaded, cleared once the word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (out_load) ovalid_r <= 1'b1;
    else if (!out_stall) ovalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; n_r <= '0; drop_r <= 1'b0;
      i_r <= '0; j_r <= '0; sum_r <= '0; dcnt_r <= '0;
    end else begin
      unique case (st_r)
        S_LOAD: if (cmd_avail) begin
          if (cmd_data.store) begin
            if (32'(n_r) < CAP) begin
              b_r[n_r] <= cmd_data.bone;
              w_r[n_r] <= SW'(signed'(cmd_data.weight));
              n_r <= n_r + 1'b1;
            end else drop_r <= 1'b1;
          end
          if (cmd_data.last) begin
            i_r <= '0; j_r <= IW'(1); sum_r <= '0;
            st_r <= S_SCAN;
          end
        end
        // One j compare per cycle; a match takes the tail pair.
        S_SCAN: begin
          if (i_r >= n_r) st_r <= S_HDR;
          else if (j_r >= n_r) st_r <= S_FIN;
          else if (b_r[j_r] == b_r[i_r]) begin
            w_r[i_r] <= w_r[i_r] + w_r[j_r];
            b_r[j_r] <= b_r[n_r-1'b1];
            w_r[j_r] <= w_r[n_r-1'b1];
            n_r <= n_r - 1'b1;
          end else j_r <= j_r + 1'b1;
        end
        S_FIN: begin
          c_r[i_r] <= !(w_r[i_r] > 0);
          if (!(w_r[i_r] > 0)) w_r[i_r] <= '0;
          else sum_r <= sum_r + w_r[i_r];
          i_r <= i_r + 1'b1; j_r <= i_r + IW'(2);
          st_r <= S_SCAN;
        end
        S_HDR: if (out_free) begin
          odata_r <= '{is_header: 1'b1, pair_count: 4'(n_r), out_bone: 8'd0,
                       weight_code: 8'd0, clamped_flag: 1'b0,
                       sum_off_flag: lhs > rhs, overflow_flag: drop_r,
                       out_last: n_r == '0};
          i_r <= '0;
          st_r <= (n_r == '0) ? S_DONE : S_DIV;
          quo_r <= '0; rem_r <= '0; dcnt_r <= '0;
        end
        // Restoring divide, one quotient bit per cycle.
        S_DIV: begin
          if (dcnt_r == '0) begin
            quo_r <= num; rem_r <= '0; dcnt_r <= 6'(DW);
          end else begin
            if (!trial[DW]) rem_r <= trial[DW-1:0];
            else rem_r <= {rem_r[DW-2:0], quo_r[DW-1]};
            quo_r <= {quo_r[DW-2:0], !trial[DW]};
            dcnt_r <= dcnt_r - 6'd1;
            if (dcnt_r == 6'd1) st_r <= S_EMIT;
          end
        end
        S_EMIT: if (out_free) begin
          odata_r <= '{is_header: 1'b0, pair_count: 4'd0, out_bone: b_r[i_r],
                       weight_code: (sum_r <= 0) ? 8'd0 :
                         (quo_r > DW'(255)) ? 8'd255 : quo_r[7:0],
                       clamped_flag: c_r[i_r], sum_off_flag: 1'b0,
                       overflow_flag: 1'b0, out_last: i_r + 1'b1 == n_r};
          i_r <= i_r + 1'b1; dcnt_r <= '0;
          st_r <= (i_r + 1'b1 == n_r) ? S_DONE : S_DIV;
        end
        S_DONE: begin
          n_r <= '0; drop_r <= 1'b0; st_r <= S_LOAD;
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  // Checks.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) 32'(n_r) <= CAP)
    else $error("pair count over capacity");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> st_r == S_LOAD) else $error("queue read outside load");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && out_stall) |=> ovalid_r) else $error("word lost under stall");
endmodule
`default_nettype wire

// ----- hdl/skin_weight_merge_normalize_pack_unit.sv -----
//------------------------------------------------------------------------------
// skin_weight_merge_normalize_pack_unit
// Merges, normalizes and packs one vertex's bone weights to 8-bit codes.
//------------------------------------------------------------------------------
// Usage: send one (bone, weight) word per pair on in_; the word with
// last_pair closes the vertex. Words with neither flag are dropped. The
// front part passes words into a four-entry queue, so input is taken at one
// word per cycle while the queue has room. The back part stores a pair per
// cycle, then merges with one bone compare per cycle, emits a header, and
// runs a bit-serial divider (one load, 39 quotient bits, one output) before
// each pair word. cfg_ writes sum_tolerance, only while idle; this binds the
// user, as the block itself does not enforce it. A stall on out_ holds the
// output register and backs up the queue. Synchronous reset clears counts
// and flags and returns the tolerance to 3277.
`default_nettype none
module skin_weight_merge_normalize_pack_unit #(
  parameter int MAX_PAIRS = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire swmnp_pkg::in_word_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output swmnp_pkg::out_word_t      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [15:0]          cfg_data
);
  logic [15:0] tol_r;
  logic cmd_wr, full, avail, take;
  logic cmd_w_v;
  swmnp_pkg::cmd_t cmd_w, cmd_r;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= swmnp_pkg::TOL_RESET;
    else if (cfg_we) tol_r <= cfg_data;
  end

  swmnp_front u_front (.in_valid, .in_stall, .in_data,
    .cmd_valid(cmd_w_v), .cmd_full(full), .cmd_data(cmd_w));
  assign cmd_wr = cmd_w_v;

  swmnp_queue u_queue (.clk, .rst_n, .wr_en(cmd_wr), .wr_data(cmd_w), .full,
    .rd_en(take), .not_empty(avail), .rd_data(cmd_r));

  swmnp_back #(.MAX_PAIRS(MAX_PAIRS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_back (
    .clk, .rst_n, .tol(tol_r), .cmd_avail(avail), .cmd_data(cmd_r),
    .cmd_take(take), .out_valid, .out_stall, .out_data);
endmodule
`default_nettype wire

// ----- bench/skin_weight_merge_normalize_pack_unit_checker.sv -----
//------------------------------------------------------------------------------
// skin_weight_merge_normalize_pack_unit_checker
// Watches both channels of the unit, predicts each vertex's output words and
// compares them in order with what the unit emits.
//------------------------------------------------------------------------------
`default_nettype none
module skin_weight_merge_normalize_pack_unit_checker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire swmnp_pkg::in_word_t  in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire swmnp_pkg::out_word_t out_data,
  input  wire logic                 cfg_we,
  input  wire logic [15:0]          cfg_data,
  output int                        fail_count,
  output int                        pending_words,
  output int                        vertices_seen
);
  localparam int CAP = 15;

  logic [15:0]       tolerance;
  logic [7:0]        held_bones [CAP];
  logic signed [23:0] held_weights [CAP];
  int                held_count;
  logic              dropped;
  swmnp_pkg::out_word_t expected_words [$];

  // Build the merged, normalized words of one vertex.
  task automatic close_vertex();
    logic [7:0]         b [CAP];
    longint             w [CAP];
    logic               clamp [CAP];
    int                 n;
    longint             sum;
    longint             sum_dev;
    longint             code;
    swmnp_pkg::out_word_t word;
    n = held_count;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      b[i] = held_bones[i];
      w[i] = held_weights[i];
      clamp[i] = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (b[j] == b[i]) begin
          w[i] += w[j];
          n--;
          b[j] = b[n];
          w[j] = w[n];
          j--;
        end
      end
      if (!(w[i] > 0)) begin
        w[i] = 0;
        clamp[i] = 1'b1;
      end
      sum += w[i];
    end
    sum_dev = (sum >= 65536) ? sum - 65536 : 65536 - sum;
    word = '0;
    word.is_header = 1'b1;
    word.pair_count = n[3:0];
    word.sum_off_flag = (sum_dev > longint'(tolerance));
    word.overflow_flag = dropped;
    word.out_last = (n == 0);
    expected_words.push_back(word);
    for (int i = 0; i < n; i++) begin
      code = 0;
      if (sum > 0) begin
        code = (510 * w[i] + sum) / (2 * sum);
        if (code > 255) code = 255;
      end
      word = '0;
      word.out_bone = b[i];
      word.weight_code = code[7:0];
      word.clamped_flag = clamp[i];
      word.out_last = (i + 1 == n);
      expected_words.push_back(word);
    end
    held_count = 0;
    dropped = 1'b0;
    vertices_seen++;
  endtask

  // Track configuration, accepted input words and emitted output words.
  always @(posedge clk) begin
    if (!rst_n) begin
      tolerance <= swmnp_pkg::TOL_RESET;
      held_count = 0;
      dropped = 1'b0;
      fail_count = 0;
      vertices_seen = 0;
    end else begin
      if (cfg_we) tolerance <= cfg_data;
      if (in_valid && !in_stall) begin
        if (in_data.pair_valid) begin
          if (held_count < CAP) begin
            held_bones[held_count] = in_data.bone_index;
            held_weights[held_count] = in_data.bone_weight;
            held_count++;
          end else begin
            dropped = 1'b1;
          end
        end
        if (in_data.last_pair) close_vertex();
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          if (expected_words[0] !== out_data) begin
            $display("%0t: word differs, expected %p, actual %p", $time,
                     expected_words[0], out_data);
            fail_count++;
          end
          void'(expected_words.pop_front());
        end
      end
    end
    pending_words = expected_words.size();
  end
endmodule
`default_nettype wire

// ----- bench/skin_weight_merge_normalize_pack_unit_tb.sv -----
//------------------------------------------------------------------------------
// skin_weight_merge_normalize_pack_unit_tb
// Drives vertices of bone and weight words through the unit under several
// tolerance settings and idle patterns, and reports the checker's verdict.
//------------------------------------------------------------------------------
`default_nettype none
module skin_weight_merge_normalize_pack_unit_tb;
  localparam int LIMIT_CYCLES = 1500000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  swmnp_pkg::in_word_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  swmnp_pkg::out_word_t out_data;
  logic       cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  int         fail_count;
  int         pending_words;
  int         vertices_seen;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_off = 1'b0;
  int         cycle_count = 0;
  int         words_sent = 0;

  always #6 clk = ~clk;

  skin_weight_merge_normalize_pack_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  skin_weight_merge_normalize_pack_unit_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_words(pending_words),
    .vertices_seen(vertices_seen)
  );

  // Receiver stall pattern, overridden by a long hold-off.
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("skin_weight_merge_normalize_pack_unit: mismatch");
      $finish;
    end
  end

  // Offer one word and hold it until accepted, with random gaps before it.
  // Valid and data change only at the falling edge, so a word that follows
  // directly simply overwrites the idle value in the same step.
  task automatic send_word(input logic [7:0] bone, input logic [23:0] weight,
                           input logic valid_pair, input logic last);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_data = '{bone_index: bone, bone_weight: weight,
                pair_valid: valid_pair, last_pair: last};
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    words_sent++;
  endtask

  // One vertex of random pairs, drawn from a small bone set to force merges unless wide_bones is set.
  task automatic send_vertex(input int pairs, input bit wide_bones);
    logic [7:0]  bone;
    logic [23:0] weight;
    for (int p = 0; p < pairs; p++) begin
      bone = wide_bones ? 8'($urandom) : 8'($urandom_range(5));
      case ($urandom_range(3))
        0: weight = 24'($urandom);
        1: weight = 24'($urandom_range(65536));
        2: weight = 24'(-int'($urandom_range(20000)));
        default: weight = 24'(65536 / (pairs + 1));
      endcase
      if ($urandom_range(19) == 0)
        send_word(8'($urandom), 24'($urandom), 1'b0, 1'b0);
      send_word(bone, weight, 1'b1, p == pairs - 1);
    end
    if (pairs == 0) send_word(8'($urandom), 24'($urandom), 1'b0, 1'b1);
  endtask

  // Wait until all words are out, then let the unit settle before a write.
  task automatic drain();
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [15:0] value);
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int mode;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, empty items, empty vertex, zero sum, overflow.
    send_word(8'd0, 24'h7FFFFF, 1'b1, 1'b0);
    send_word(8'd255, 24'h800000, 1'b1, 1'b1);
    send_word(8'd0, 24'd0, 1'b0, 1'b0);
    send_word(8'd0, 24'd0, 1'b0, 1'b1);
    send_word(8'd7, 24'd0, 1'b1, 1'b0);
    send_word(8'd7, 24'hFFFFFF, 1'b1, 1'b1);
    send_word(8'd3, 24'd32768, 1'b1, 1'b0);
    send_word(8'd3, 24'd32768, 1'b1, 1'b1);
    send_word(8'd1, 24'd65536, 1'b1, 1'b1);
    for (int p = 0; p < 16; p++) send_word(8'(p), 24'd4096, 1'b1, p == 15);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_tolerance(16'd0);
        1: write_tolerance(16'hFFFF);
        2: write_tolerance(16'd3277);
        default: write_tolerance(16'($urandom));
      endcase
      mode = phase % 4;
      send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 3) ? 22 : 60) : 0;
      recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 22 : 60) : 0;
      if (phase == 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
          begin
            hold_off = 1'b1;
            repeat (3000) @(negedge clk);
            hold_off = 1'b0;
          end
          repeat (8) send_vertex($urandom_range(1, 4), 1'b1);
        join
      end
      for (int v = 0; v < 22; v++) begin
        if ($urandom_range(9) == 0) send_vertex($urandom_range(0, 17), 1'b1);
        else send_vertex($urandom_range(1, 6), $urandom_range(1));
      end
      drain();
    end

    repeat (200) @(negedge clk);
    $display("Sent %0d input words over %0d vertices across five tolerance settings",
             words_sent, vertices_seen);
    $display("with sender gaps, receiver stalls and one long output hold-off.");
    if (fail_count == 0 && pending_words == 0) begin
      $display("skin_weight_merge_normalize_pack_unit: match");
    end else begin
      $display("skin_weight_merge_normalize_pack_unit: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
